@@ hw/rtl/rtmb_pkg.sv @@
// Shared types and constants for the RGBA row to monochrome bit packer.
`default_nettype none

package rtmb_pkg;

    // Luma weights and the white decision threshold.
    localparam logic [7:0]  LUMA_R          = 8'd77;
    localparam logic [7:0]  LUMA_G          = 8'd150;
    localparam logic [7:0]  LUMA_B          = 8'd29;
    localparam logic [15:0] WHITE_THRESHOLD = 16'h8000;

    // Compositing over white: (c*a + 255*(255-a) + 127) / 255.
    localparam logic [7:0]  FULL_SCALE      = 8'd255;
    localparam logic [15:0] ROUND_BIAS      = 16'd127;

    // Bit packing.
    localparam int unsigned BYTE_BITS       = 8;
    localparam int unsigned SLOT_W          = $clog2(BYTE_BITS);
    localparam logic [BYTE_BITS-1:0] FIRST_BIT = 8'h80;

    // Queue between the classifier and the packer.
    localparam int unsigned FIFO_AW         = 3;
    localparam int unsigned FIFO_DEPTH      = 1 << FIFO_AW;
    localparam int unsigned FIFO_CW         = FIFO_AW + 1;

    // Front pipeline: two register stages hold pixels in flight.
    localparam int unsigned FRONT_STAGES    = 2;
    localparam int unsigned INFLIGHT_W      = $clog2(FRONT_STAGES + 1);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_end;
    } t_pixel;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       row_last;
    } t_result;

    // One classified pixel as it travels from the front to the packer.
    typedef struct packed {
        logic white;
        logic row_end;
    } t_cls_item;

    typedef struct packed {
        logic                  valid;
        t_cls_item             item;
        logic [INFLIGHT_W-1:0] inflight;
    } t_front_status;

    typedef struct packed {
        logic                  not_empty;
        t_cls_item             head;
        logic [FIFO_CW-1:0]    count;
    } t_fifo_status;

endpackage

`default_nettype wire

@@ hw/rtl/rtmb_front.sv @@
// Front pipeline: composites each pixel over white and classifies it as a white or black bit.
`default_nettype none

module rtmb_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire rtmb_pkg::t_pixel       i_pixel,
    output rtmb_pkg::t_front_status     o_status
);

    // Stage one: products and the alpha bias.
    logic        r_s1_valid;
    logic [15:0] r_s1_prod_r;
    logic [15:0] r_s1_prod_g;
    logic [15:0] r_s1_prod_b;
    logic [15:0] r_s1_bias;
    logic        r_s1_row_end;

    // Stage two: composited channels.
    logic        r_s2_valid;
    logic [7:0]  r_s2_r;
    logic [7:0]  r_s2_g;
    logic [7:0]  r_s2_b;
    logic        r_s2_row_end;

    logic [7:0]  inv_alpha;
    logic [15:0] n_bias;
    logic [7:0]  n_comp_r;
    logic [7:0]  n_comp_g;
    logic [7:0]  n_comp_b;
    logic [15:0] luma;

    // Rounded division by 255 for x below 65280: (x + (x >> 8) + 1) >> 8.
    function automatic logic [7:0] div255(input logic [15:0] prod, input logic [15:0] bias);
        logic [15:0] x;
        logic [15:0] t;
        x = prod + bias;
        t = x + {8'd0, x[15:8]} + 16'd1;
        return t[15:8];
    endfunction

    assign inv_alpha = rtmb_pkg::FULL_SCALE - i_pixel.alpha;
    assign n_bias    = {8'd0, inv_alpha} * {8'd0, rtmb_pkg::FULL_SCALE} + rtmb_pkg::ROUND_BIAS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_prod_r  <= {8'd0, i_pixel.red}   * {8'd0, i_pixel.alpha};
        r_s1_prod_g  <= {8'd0, i_pixel.green} * {8'd0, i_pixel.alpha};
        r_s1_prod_b  <= {8'd0, i_pixel.blue}  * {8'd0, i_pixel.alpha};
        r_s1_bias    <= n_bias;
        r_s1_row_end <= i_pixel.row_end;
        r_s2_r       <= n_comp_r;
        r_s2_g       <= n_comp_g;
        r_s2_b       <= n_comp_b;
        r_s2_row_end <= r_s1_row_end;
    end

    assign n_comp_r = div255(r_s1_prod_r, r_s1_bias);
    assign n_comp_g = div255(r_s1_prod_g, r_s1_bias);
    assign n_comp_b = div255(r_s1_prod_b, r_s1_bias);

    // Weights sum to 256, so the luma never exceeds 16 bits.
    assign luma = {8'd0, rtmb_pkg::LUMA_R} * {8'd0, r_s2_r}
                + {8'd0, rtmb_pkg::LUMA_G} * {8'd0, r_s2_g}
                + {8'd0, rtmb_pkg::LUMA_B} * {8'd0, r_s2_b};

    always_comb begin
        o_status.valid        = r_s2_valid;
        o_status.item.white   = (luma >= rtmb_pkg::WHITE_THRESHOLD);
        o_status.item.row_end = r_s2_row_end;
        o_status.inflight     = rtmb_pkg::INFLIGHT_W'({1'b0, r_s1_valid})
                              + rtmb_pkg::INFLIGHT_W'({1'b0, r_s2_valid});
    end

endmodule

`default_nettype wire

@@ hw/rtl/rtmb_fifo.sv @@
// Short queue of classified pixel bits between the front pipeline and the packer.
`default_nettype none

module rtmb_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr,
    input  wire rtmb_pkg::t_cls_item i_data,
    input  wire logic                i_rd,
    output rtmb_pkg::t_fifo_status   o_status
);

    rtmb_pkg::t_cls_item                r_mem [rtmb_pkg::FIFO_DEPTH];
    logic [rtmb_pkg::FIFO_AW-1:0]       r_wr_ptr;
    logic [rtmb_pkg::FIFO_AW-1:0]       r_rd_ptr;
    logic [rtmb_pkg::FIFO_CW-1:0]       r_count;
    logic                               do_rd;

    assign do_rd = i_rd && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && do_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_comb begin
        o_status.not_empty = (r_count != '0);
        o_status.head      = r_mem[r_rd_ptr];
        o_status.count     = r_count;
    end

endmodule

`default_nettype wire

@@ hw/rtl/rtmb_back.sv @@
// Packer: gathers pixel bits most significant first and holds finished bytes for the consumer.
`default_nettype none

module rtmb_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rtmb_pkg::t_fifo_status i_fifo,
    output logic                       o_fifo_rd,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output rtmb_pkg::t_result          o_result
);

    logic [rtmb_pkg::BYTE_BITS-1:0] r_partial;
    logic [rtmb_pkg::SLOT_W-1:0]    r_slot;
    logic                           r_out_valid;
    rtmb_pkg::t_result              r_out;

    logic                           emit;
    logic                           out_free;
    logic [rtmb_pkg::BYTE_BITS-1:0] n_partial;

    assign emit      = (r_slot == rtmb_pkg::SLOT_W'(rtmb_pkg::BYTE_BITS - 1))
                    || i_fifo.head.row_end;
    assign out_free  = !r_out_valid || i_pop;
    assign o_fifo_rd = i_fifo.not_empty && (!emit || out_free);
    assign n_partial = i_fifo.head.white ? (r_partial | (rtmb_pkg::FIRST_BIT >> r_slot))
                                         : r_partial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_fifo_rd && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (o_fifo_rd) begin
                if (emit) begin
                    r_partial <= '0;
                    r_slot    <= '0;
                end else begin
                    r_partial <= n_partial;
                    r_slot    <= r_slot + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fifo_rd && emit) begin
            r_out.packed_byte <= n_partial;
            r_out.row_last    <= i_fifo.head.row_end;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/rgba_row_to_monochrome_bits_unit.sv @@
// Top level of the RGBA row to one-bit-per-pixel packer.
// Path: a pixel that completes a byte goes through both front stages and the queue, and its
//   byte is then registered and shown on o_result once the output register is free.
// Throughput: one pixel beat per cycle while full is low, set by the two-stage compositing
//   pipeline and the packer; a byte beat may leave every cycle while pop is held high.
// Reset: i_rst_n is synchronous and active low; it empties all stages and starts a new byte.
`default_nettype none

module rgba_row_to_monochrome_bits_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire rtmb_pkg::t_pixel  i_pixel,
    output logic                   empty,
    input  wire logic              pop,
    output rtmb_pkg::t_result      o_result
);

    // The front pipeline never stalls. Instead, a pixel is only taken when the
    // queue has room for it and for every pixel still in flight in the front,
    // so each classified bit always finds a free queue slot.

    rtmb_pkg::t_front_status front_status;
    rtmb_pkg::t_fifo_status  fifo_status;
    logic                    accept;
    logic                    fifo_rd;
    logic [rtmb_pkg::FIFO_CW-1:0] committed;

    assign committed = fifo_status.count
                     + rtmb_pkg::FIFO_CW'(front_status.inflight);
    assign full      = (committed >= rtmb_pkg::FIFO_CW'(rtmb_pkg::FIFO_DEPTH));
    assign accept    = push && !full;

    // Compositing over white and the luma threshold.
    rtmb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_pixel  (i_pixel),
        .o_status (front_status)
    );

    // Decoupling queue of classified bits.
    rtmb_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (front_status.valid),
        .i_data   (front_status.item),
        .i_rd     (fifo_rd),
        .o_status (fifo_status)
    );

    // Bit packing and the output holding register.
    rtmb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fifo    (fifo_status),
        .o_fifo_rd (fifo_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

    // The credit scheme must never let the queue and the front pipeline together
    // hold more pixels than the queue can take.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        committed <= rtmb_pkg::FIFO_CW'(rtmb_pkg::FIFO_DEPTH))
        else $error("front and queue hold more pixels than the queue depth");

    // A classified bit must never arrive at a full queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_status.valid |->
            (fifo_status.count < rtmb_pkg::FIFO_CW'(rtmb_pkg::FIFO_DEPTH)) || fifo_rd)
        else $error("classified bit written into a full queue");

    // The packer only reads from a queue that holds something.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_rd |-> fifo_status.not_empty)
        else $error("packer read from an empty queue");

    // Reset leaves no result waiting.
    assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the RGBA row to one-bit-per-pixel packer.
`timescale 1ns / 100ps

module testbench;

    // Run length and the lengths of the deliberate pauses.
    localparam int unsigned PIXEL_ITEMS  = 1050;
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned PAUSE_AT     = 650;

    // Keeps its own copy of the byte being gathered, predicts every byte beat
    // from the pixel beats that the block accepts, and checks the byte beats
    // that leave the block against those predictions in order.
    class mono_byte_scoreboard;
        logic [7:0] gathered;
        logic [2:0] slot;
        rtmb_pkg::t_result expected_bytes[$];
        int unsigned faults;

        function new();
            gathered = '0;
            slot     = '0;
            faults   = 0;
        endfunction

        // Composites one channel over white, rounding to nearest.
        function int unsigned blend_on_paper(int unsigned c, int unsigned a);
            return (c * a + 255 * (255 - a) + 127) / 255;
        endfunction

        function bit is_white(rtmb_pkg::t_pixel p);
            int unsigned luma;
            luma = rtmb_pkg::LUMA_R * blend_on_paper(p.red, p.alpha)
                 + rtmb_pkg::LUMA_G * blend_on_paper(p.green, p.alpha)
                 + rtmb_pkg::LUMA_B * blend_on_paper(p.blue, p.alpha);
            return luma >= rtmb_pkg::WHITE_THRESHOLD;
        endfunction

        function void note_pixel(rtmb_pkg::t_pixel p);
            rtmb_pkg::t_result done;
            if (is_white(p)) begin
                gathered = gathered | (rtmb_pkg::FIRST_BIT >> slot);
            end
            if (slot == 3'd7 || p.row_end) begin
                done.packed_byte = gathered;
                done.row_last    = p.row_end;
                expected_bytes.push_back(done);
                gathered = '0;
                slot     = '0;
            end else begin
                slot = slot + 3'd1;
            end
        endfunction

        function void check_byte(rtmb_pkg::t_result got);
            rtmb_pkg::t_result want;
            if (expected_bytes.size() == 0) begin
                $error("byte beat 0x%02h (row_last %0b) arrived with nothing outstanding",
                       got.packed_byte, got.row_last);
                faults++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.packed_byte !== want.packed_byte) begin
                $error("packed_byte: expected 0x%02h, actual 0x%02h",
                       want.packed_byte, got.packed_byte);
                faults++;
            end
            if (got.row_last !== want.row_last) begin
                $error("row_last: expected %0b, actual %0b", want.row_last, got.row_last);
                faults++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_bytes.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    rtmb_pkg::t_pixel  i_pixel;
    logic              empty;
    logic              pop;
    rtmb_pkg::t_result o_result;

    mono_byte_scoreboard sb;

    // The sender raises hold_req to ask for one long hold-off, and the
    // receiver raises hold_done once that hold-off is over.
    bit          hold_req;
    bit          hold_done;
    int unsigned burst_left;
    int unsigned pixels_sent;

    rgba_row_to_monochrome_bits_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_pixel  (i_pixel),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Fails the run if the drain never completes.
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic rtmb_pkg::t_pixel make_pixel(logic [7:0] r, logic [7:0] g,
                                                    logic [7:0] b, logic [7:0] a,
                                                    logic last);
        rtmb_pkg::t_pixel p;
        p.red     = r;
        p.green   = g;
        p.blue    = b;
        p.alpha   = a;
        p.row_end = last;
        return p;
    endfunction

    // Mostly free random colours, with a good share of greys close to the
    // white threshold and of fully opaque or fully transparent pixels, since
    // those are where rounding and the threshold compare are most fragile.
    function automatic rtmb_pkg::t_pixel random_pixel(logic last);
        logic [7:0]       grey;
        rtmb_pkg::t_pixel p;
        p = make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), last);
        case ($urandom_range(0, 7))
            0, 1: begin
                grey    = 8'($urandom_range(118, 138));
                p.red   = grey;
                p.green = grey;
                p.blue  = grey;
                p.alpha = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom_range(120, 255));
            end
            2: begin
                p.alpha = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            end
            3: begin
                p.alpha = 8'($urandom_range(125, 130));
            end
            default: begin
            end
        endcase
        return p;
    endfunction

    // Offers one pixel beat and returns once it has been taken. The sender
    // works in bursts; between bursts it leaves a random gap, which may be
    // empty so that long unbroken streams also occur. While the receiver is
    // being held off the gaps are skipped, so that the block really fills.
    task automatic offer_pixel(input rtmb_pkg::t_pixel p);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ((hold_req && !hold_done) || $urandom_range(0, 3) == 0) begin
                gap = 0;
            end else begin
                gap = $urandom_range(1, 6);
            end
            repeat (gap) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        push    <= 1'b1;
        i_pixel <= p;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_pixel(p);
        pixels_sent++;
    endtask

    task automatic wait_for_all_bytes();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Receiver: pops in modes of random length, from always ready through
    // random and periodic stalls to mostly stalled. When asked, it holds off
    // completely for a long, counted stretch.
    initial begin : receiver
        int unsigned mode;
        int unsigned span;
        int unsigned phase;
        phase     = 0;
        pop       = 1'b0;
        hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 60);
            repeat (span) begin
                @(negedge i_clk);
                phase++;
                if (hold_req && !hold_done) begin
                    pop <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    hold_done = 1'b1;
                end else begin
                    case (mode)
                        0:       pop <= 1'b1;
                        1:       pop <= 1'($urandom_range(0, 1));
                        2:       pop <= (phase % 5) >= 2;
                        default: pop <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // Every accepted byte beat is checked against the oldest prediction. The
    // outputs are read at the rising edge, before the block updates them.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_byte(o_result);
        end
    end

    initial begin : sender
        int unsigned row_len;
        int unsigned k;
        bit          held;
        bit          paused;

        sb          = new();
        hold_req    = 1'b0;
        burst_left  = 0;
        pixels_sent = 0;
        held        = 1'b0;
        paused      = 1'b0;
        push        = 1'b0;
        i_pixel     = '0;
        i_rst_n     = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A full byte inside a row: black, white, transparent over white, the
        // greys either side of the threshold and the pure red and green primaries.
        offer_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0));
        offer_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        offer_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0));
        offer_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        offer_pixel(make_pixel(8'd127, 8'd127, 8'd127, 8'hFF, 1'b0));
        offer_pixel(make_pixel(8'd128, 8'd128, 8'd128, 8'hFF, 1'b0));
        offer_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0));
        offer_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0));

        // The row ends exactly on the eighth pixel of a byte. Black at half
        // alpha sits on either side of the threshold depending on rounding.
        offer_pixel(make_pixel(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0));
        offer_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'd128, 1'b0));
        offer_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'd127, 1'b0));
        offer_pixel(make_pixel(8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b0));
        offer_pixel(make_pixel(8'h00, 8'hFF, 8'hFF, 8'h01, 1'b0));
        offer_pixel(make_pixel(8'd200, 8'd50, 8'd10, 8'd200, 1'b0));
        offer_pixel(make_pixel(8'd10, 8'd200, 8'd250, 8'd60, 1'b0));
        offer_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));

        // The row ends part way through a byte, and a row of a single pixel.
        offer_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        offer_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0));
        offer_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        offer_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1));

        // Random rows, mostly short so that row ends fall on every slot of a
        // byte, with an occasional long row of several whole bytes.
        while (pixels_sent < PIXEL_ITEMS) begin
            if (!held && pixels_sent >= HOLD_AT) begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && pixels_sent >= PAUSE_AT) begin
                paused = 1'b1;
                wait_for_all_bytes();
            end
            if ($urandom_range(0, 9) == 0) begin
                row_len = $urandom_range(25, 64);
            end else begin
                row_len = $urandom_range(1, 24);
            end
            for (k = 1; k <= row_len; k++) begin
                offer_pixel(random_pixel(k == row_len));
            end
        end

        wait_for_all_bytes();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.faults == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
